/* hw/rtl/sofa_pkg.sv */
package sofa_pkg;

  // result count per pass: overlap plus nine wavevectors
  localparam int unsigned NUM_COMP  = 10;
  localparam int unsigned NUM_FREQ  = NUM_COMP - 1;
  localparam int unsigned NUM_FSUMS = 2 * NUM_FREQ;

  // bits in one multispin word
  localparam int WORD_BITS = 32;

  // one lattice site word
  typedef struct packed {
    logic [WORD_BITS-1:0] spin_word_a;
    logic [WORD_BITS-1:0] spin_word_b;
    logic                 last_site;
  } site_word_t;

  // one result word
  typedef struct packed {
    logic [3:0]         component;
    logic signed [31:0] real_sum;
    logic signed [31:0] imag_sum;
    logic               last_result;
  } result_word_t;

  // snapshot of all sums; real at 2*(c-1), imag at 2*(c-1)+1 for component c
  typedef struct packed {
    logic signed [31:0]               overlap;
    logic [NUM_FSUMS-1:0][31:0]       fsum;
  } sums_t;

  // handoff between the accumulator and the result bank
  typedef struct packed {
    logic load;
    logic load_ok;
  } bank_ctl_t;

endpackage

/* hw/rtl/sofa_trig_rom.sv */
module sofa_trig_rom #(
  parameter int SIDE_LEN = 16
) (
  input  logic [$clog2(SIDE_LEN)-1:0] angle,
  output logic signed [15:0]          cos_v,
  output logic signed [15:0]          sin_v
);

  localparam logic [63:0] ONE_Q30     = 64'd1073741824;
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  // series term divisors (2k+1)(2k+2) and (2k+2)(2k+3)
  localparam int unsigned DIV_C [12] =
    '{2, 12, 30, 56, 90, 132, 182, 240, 306, 380, 462, 552};
  localparam int unsigned DIV_S [12] =
    '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420, 506, 600};

  typedef struct packed {
    logic signed [15:0] cos_v;
    logic signed [15:0] sin_v;
  } rom_pair_t;

  // round a Q30 value to Q1.15 with clamping
  function automatic logic signed [15:0] to_rom(input logic signed [63:0] v);
    logic [63:0]        m;
    logic signed [15:0] r;
    m = (v < 0) ? 64'(-v) : 64'(v);
    m = (m + 64'd16384) >> 15;
    if (v < 0) begin
      r = (m > 64'd32768) ? -16'sd32768 : 16'(64'd0 - m);
    end else begin
      r = (m > 64'd32767) ? 16'sd32767 : 16'(m);
    end
    return r;
  endfunction

  // integer Taylor series in the first quadrant, then quadrant rotation
  function automatic rom_pair_t rom_pair(input logic [63:0] phi, input logic [1:0] quad);
    logic [63:0]        x2;
    logic [63:0]        tc;
    logic [63:0]        ts;
    logic signed [63:0] sc;
    logic signed [63:0] ss;
    logic signed [63:0] co;
    logic signed [63:0] si;
    rom_pair_t          p;
    x2 = (phi * phi) >> 30;
    tc = ONE_Q30;
    ts = phi;
    sc = '0;
    ss = '0;
    for (int k = 0; k < 12; k++) begin
      if ((k & 1) == 0) begin
        sc = sc + $signed(tc);
        ss = ss + $signed(ts);
      end else begin
        sc = sc - $signed(tc);
        ss = ss - $signed(ts);
      end
      tc = ((tc * x2) >> 30) / 64'(DIV_C[k]);
      ts = ((ts * x2) >> 30) / 64'(DIV_S[k]);
    end
    unique case (quad)
      2'd0: begin co = sc;  si = ss;  end
      2'd1: begin co = -ss; si = sc;  end
      2'd2: begin co = -sc; si = -ss; end
      default: begin co = ss; si = -sc; end
    endcase
    p.cos_v = to_rom(co);
    p.sin_v = to_rom(si);
    return p;
  endfunction

  logic signed [15:0] cos_tab [SIDE_LEN];
  logic signed [15:0] sin_tab [SIDE_LEN];

  // constant table, one entry per angle step of 2*pi/SIDE_LEN
  for (genvar n = 0; n < SIDE_LEN; n++) begin : g_ent
    localparam int unsigned QUAD = (4 * n) / SIDE_LEN;
    localparam int unsigned REM4 = 4 * n - QUAD * SIDE_LEN;
    localparam logic [63:0] PHI  = (PI_HALF_Q30 * 64'(REM4)) / 64'(SIDE_LEN);
    localparam rom_pair_t   ENT  = rom_pair(PHI, QUAD[1:0]);
    assign cos_tab[n] = ENT.cos_v;
    assign sin_tab[n] = ENT.sin_v;
  end

  // lookup
  assign cos_v = cos_tab[angle];
  assign sin_v = sin_tab[angle];

endmodule

/* hw/rtl/sofa_result_bank.sv */
module sofa_result_bank (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  output logic                   load_ok,
  input  sofa_pkg::sums_t        sums,
  output logic                   res_valid,
  input  logic                   res_stall,
  output sofa_pkg::result_word_t res
);

  localparam logic [3:0] LAST_IDX = 4'(sofa_pkg::NUM_COMP - 1);

  logic               bank_valid;
  logic [3:0]         idx;
  logic signed [31:0] bank_re [sofa_pkg::NUM_COMP];
  logic signed [31:0] bank_im [sofa_pkg::NUM_COMP];
  logic               take;
  logic               take_last;

  assign take      = bank_valid && !res_stall;
  assign take_last = take && (idx == LAST_IDX);
  // a new snapshot may land as the final word of the old one leaves
  assign load_ok   = !bank_valid || take_last;

  // emit position and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      bank_valid <= 1'b0;
      idx        <= '0;
    end else if (load) begin
      bank_valid <= 1'b1;
      idx        <= '0;
    end else if (take_last) begin
      bank_valid <= 1'b0;
      idx        <= '0;
    end else if (take) begin
      idx <= idx + 4'd1;
    end
  end

  // snapshot storage
  always_ff @(posedge clk) begin
    if (load) begin
      bank_re[0] <= sums.overlap;
      bank_im[0] <= '0;
      for (int c = 1; c < sofa_pkg::NUM_COMP; c++) begin
        bank_re[c] <= $signed(sums.fsum[2 * (c - 1)]);
        bank_im[c] <= $signed(sums.fsum[2 * (c - 1) + 1]);
      end
    end
  end

  // result word
  assign res_valid       = bank_valid;
  assign res.component   = idx;
  assign res.real_sum    = bank_re[idx];
  assign res.imag_sum    = bank_im[idx];
  assign res.last_result = (idx == LAST_IDX);

  a_load_ok : assert property (@(posedge clk) disable iff (rst) load |-> load_ok)
    else $error("snapshot loaded over undelivered results");

  a_idx_range : assert property (@(posedge clk) disable iff (rst)
    bank_valid |-> (idx <= LAST_IDX))
    else $error("result index past last component");

  a_step : assert property (@(posedge clk) disable iff (rst)
    (take && !take_last && !load) |=> (res_valid && idx == $past(idx) + 4'd1))
    else $error("result index did not advance after a take");

  a_load : assert property (@(posedge clk) disable iff (rst)
    load |=> (res_valid && idx == '0 && res.real_sum == $past(sums.overlap)))
    else $error("snapshot did not start with the overlap count");

endmodule

/* hw/rtl/spin_overlap_fourier_accumulator_top.sv */
// Spin overlap and Fourier sum accumulator.
// Site channel (site_valid / site_stall / site): one word per lattice site, in
// site order with x fastest, then y, then z; last_site marks the final site.
// The block XORs the two replica words, takes the bit set by beta_bit and adds
// +1 or -1 into the overlap count and, times a Q1.15 cosine and sine, into 18
// saturating Fourier sums along x, y, z and the six pair diagonals.
// Result channel (res_valid / res_stall / res): after a last site, ten words
// leave in component order, the tenth with last_result set.
// Throughput: one site per cycle while site_stall is low, set by the single
// accumulate stage behind the input register. A last site leaves the input
// register as its sums load the result bank; the first result word follows,
// the rest one per cycle while res_stall is low. site_stall rises only while
// a last site waits for the previous ten results to drain; a stalled result
// channel backs up into the site channel only through that case.
// cfg_we / cfg_wdata write beta_bit; write it only while the block is idle.
// Reset (rst, synchronous) clears beta_bit, coordinates, sums and both
// channels; the trig table is constant logic and needs no fill.
module spin_overlap_fourier_accumulator_top #(
  parameter int SIDE_LEN  = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [4:0]             cfg_wdata,
  input  logic                   site_valid,
  output logic                   site_stall,
  input  sofa_pkg::site_word_t   site,
  output logic                   res_valid,
  input  logic                   res_stall,
  output sofa_pkg::result_word_t res
);

  localparam int          CW       = $clog2(SIDE_LEN);
  localparam logic [CW:0] SIDE_W   = (CW + 1)'(SIDE_LEN);
  localparam logic [CW-1:0] MAX_CO = CW'(SIDE_LEN - 1);

  // fold a value below twice the side length back into one period
  function automatic logic [CW-1:0] fold(input logic [CW:0] v);
    logic [CW:0] r;
    r = (v >= SIDE_W) ? v - SIDE_W : v;
    return r[CW-1:0];
  endfunction

  // saturating add of a small signed term
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [16:0] b);
    logic [32:0] t;
    logic signed [31:0] r;
    t = {a[31], a} + {{16{b[16]}}, b};
    if (t[32] != t[31]) begin
      r = t[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = t[31:0];
    end
    return r;
  endfunction

  logic [4:0]        beta_bit;
  logic              site_take;
  logic              s1_valid;
  logic              s1_neg;
  logic              s1_last;
  logic              s1_go;
  logic              bit_neg;
  logic [sofa_pkg::WORD_BITS-1:0] diff_word;
  logic [CW-1:0]     coord_x;
  logic [CW-1:0]     coord_y;
  logic [CW-1:0]     coord_z;
  sofa_pkg::sums_t   sums;
  sofa_pkg::sums_t   sums_next;
  sofa_pkg::bank_ctl_t bank_ctl;
  logic [CW-1:0]     ang [sofa_pkg::NUM_FREQ];
  logic signed [15:0] cos_v [sofa_pkg::NUM_FREQ];
  logic signed [15:0] sin_v [sofa_pkg::NUM_FREQ];

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      beta_bit <= '0;
    end else if (cfg_we) begin
      beta_bit <= cfg_wdata;
    end
  end

  // measured bit of the replica difference
  assign diff_word = site.spin_word_a ^ site.spin_word_b;
  assign bit_neg   = (int'(beta_bit) < sofa_pkg::WORD_BITS) && diff_word[beta_bit];

  // input register; holds only a last site waiting for the result bank
  assign s1_go      = s1_valid && !(s1_last && !bank_ctl.load_ok);
  assign site_stall = s1_valid && !s1_go;
  assign site_take  = site_valid && !site_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (site_take) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (site_take) begin
      s1_neg  <= bit_neg;
      s1_last <= site.last_site;
    end
  end

  // wavevector angles: x, y, z, x+y, x-y, x+z, x-z, y+z, y-z
  always_comb begin
    ang[0] = coord_x;
    ang[1] = coord_y;
    ang[2] = coord_z;
    ang[3] = fold({1'b0, coord_x} + {1'b0, coord_y});
    ang[4] = fold({1'b0, coord_x} + SIDE_W - {1'b0, coord_y});
    ang[5] = fold({1'b0, coord_x} + {1'b0, coord_z});
    ang[6] = fold({1'b0, coord_x} + SIDE_W - {1'b0, coord_z});
    ang[7] = fold({1'b0, coord_y} + {1'b0, coord_z});
    ang[8] = fold({1'b0, coord_y} + SIDE_W - {1'b0, coord_z});
  end

  for (genvar j = 0; j < sofa_pkg::NUM_FREQ; j++) begin : g_rom
    sofa_trig_rom #(
      .SIDE_LEN(SIDE_LEN)
    ) u_rom (
      .angle(ang[j]),
      .cos_v(cos_v[j]),
      .sin_v(sin_v[j])
    );
  end

  // signed terms and saturating sums
  always_comb begin
    logic signed [16:0] tc;
    logic signed [16:0] ts;
    sums_next.overlap = sat_add(sums.overlap, s1_neg ? -17'sd1 : 17'sd1);
    for (int j = 0; j < sofa_pkg::NUM_FREQ; j++) begin
      tc = {cos_v[j][15], cos_v[j]};
      ts = {sin_v[j][15], sin_v[j]};
      if (s1_neg) begin
        tc = -tc;
        ts = -ts;
      end
      sums_next.fsum[2 * j]     = sat_add($signed(sums.fsum[2 * j]), tc);
      sums_next.fsum[2 * j + 1] = sat_add($signed(sums.fsum[2 * j + 1]), ts);
    end
  end

  // accumulators and site coordinates
  always_ff @(posedge clk) begin
    if (rst) begin
      sums    <= '0;
      coord_x <= '0;
      coord_y <= '0;
      coord_z <= '0;
    end else if (s1_go) begin
      if (s1_last) begin
        sums    <= '0;
        coord_x <= '0;
        coord_y <= '0;
        coord_z <= '0;
      end else begin
        sums <= sums_next;
        if (coord_x == MAX_CO) begin
          coord_x <= '0;
          if (coord_y == MAX_CO) begin
            coord_y <= '0;
            coord_z <= (coord_z == MAX_CO) ? '0 : coord_z + 1'b1;
          end else begin
            coord_y <= coord_y + 1'b1;
          end
        end else begin
          coord_x <= coord_x + 1'b1;
        end
      end
    end
  end

  assign bank_ctl.load = s1_go && s1_last;

  sofa_result_bank u_bank (
    .clk      (clk),
    .rst      (rst),
    .load     (bank_ctl.load),
    .load_ok  (bank_ctl.load_ok),
    .sums     (sums_next),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res)
  );

  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    site_stall |-> (s1_valid && s1_last && !bank_ctl.load_ok))
    else $error("site channel stalled without a waiting last site");

  a_clear : assert property (@(posedge clk) disable iff (rst)
    bank_ctl.load |=> (sums == '0 && coord_x == '0 && coord_y == '0 && coord_z == '0))
    else $error("sums not cleared after a last site");

  a_hold : assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_go) |=> (s1_valid && s1_last && $stable(s1_neg)))
    else $error("held site lost or changed");

endmodule
